// ===== src/fixed_grid_tick_scheduler_unit_assert.svh =====
// assertion macros for the tick scheduler
`ifndef FIXED_GRID_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define FIXED_GRID_TICK_SCHEDULER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define FGTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every clock edge
`define FGTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FGTS_ASSERT(label, prop, msg)
`define FGTS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/fgts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fgts_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PERIOD_W  = 25;
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W);
  localparam int unsigned USER_IN_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 25'd1000000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 25'd33333333;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd4166666;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  typedef logic [TIME_W-1:0]   tstamp_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [PERIOD_W-1:0] period_t;

  // first member lands in the highest bits
  typedef struct packed {
    tstamp_t output_time;
    tstamp_t shaping_delay;
    tstamp_t lateness;
    count_t  skipped_ticks;
    tstamp_t scheduled_tick;
  } result_t;

  localparam int unsigned DATA_OUT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== src/fgts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fgts_div
  import fgts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire tstamp_t dividend_i,
  input  wire period_t divisor_i,
  output logic         done_o,
  output tstamp_t      quot_o,
  output period_t      rem_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  tstamp_t              dvd_q;
  period_t              rem_q;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W+1:0] diff;
  logic                ge;
  period_t             rem_d;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, dvd_q[TIME_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign ge     = ~diff[PERIOD_W+1];
  assign rem_d  = ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(TIME_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TIME_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== src/fixed_grid_tick_scheduler_unit.sv =====
// Fixed-period tick scheduler on a 48-bit integer timebase. Slave transactions carry
// time_stamp in tdata and {valid_req, op} in tuser; a submit (op 0) with valid_req 0
// clears the state, a valid submit records the request time and starts or moves the grid,
// a poll (op 1) at a due time returns one master transaction with the served tick, the
// skipped tick count, lateness, shaping delay and the poll time. An invalid submit, a poll
// that is not due and a submit that does not move the grid complete in the idle state; a
// submit that moves the grid and a due poll pass through the divide state, in which the
// serial divider produces one quotient bit per cycle, 48 bits in all, and then the finish
// state. A due poll waits in its finish state while an earlier result is still held on the
// master side. Writing the period clamps it into [1000000, 33333333] and clears the
// scheduler state; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_grid_tick_scheduler_unit_assert.svh"

module fixed_grid_tick_scheduler_unit
  import fgts_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [PERIOD_W-1:0]   cfg_wdata_i,    // period_units
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TIME_W-1:0]     s_axis_tdata,   // time_stamp
  input  wire logic [USER_IN_W-1:0]  s_axis_tuser,   // op, valid_req
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // scheduled_tick, skipped_ticks, lateness, shaping_delay, output_time
  output logic [DATA_OUT_W-1:0]      m_axis_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam int unsigned SUM_W  = TIME_W + 1;

  logic [1:0] state_q, state_d;
  period_t    period_q;
  logic       have_req_q;
  tstamp_t    req_time_q;
  tstamp_t    next_tick_q;
  count_t     pending_q;
  logic       m_valid_q;
  result_t    result_q;
  logic       op_q;
  tstamp_t    t_q;

  logic       in_op, in_valid;
  tstamp_t    in_time;
  logic       s_accept, clr_accept, poll_due, sub_move, need_div;
  tstamp_t    div_dividend;
  logic       div_done;
  tstamp_t    div_quot;
  period_t    div_rem;
  period_t    cfg_clamped;

  logic       rem_nz, inc;
  logic [SUM_W-1:0] cnt_sum;
  count_t     cnt_sat;
  logic [SUM_W-1:0] tick_sum;
  tstamp_t    tick_sat, next_fin, sched, delay;
  logic       fin_go, fin_out;
  result_t    result_d;

  assign in_op    = s_axis_tuser[0];
  assign in_valid = s_axis_tuser[1];
  assign in_time  = s_axis_tdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign clr_accept    = s_accept && (in_op == OP_SUBMIT) && !in_valid;

  assign poll_due = have_req_q && (in_time != '0) && (in_time >= next_tick_q);
  assign sub_move = (next_tick_q != '0) && (next_tick_q < in_time);
  assign need_div = s_accept && ((in_op == OP_POLL) ? poll_due : (in_valid && sub_move));
  assign div_dividend = in_time - next_tick_q;

  assign cfg_clamped = (cfg_wdata_i < PERIOD_MIN) ? PERIOD_MIN :
                       (cfg_wdata_i > PERIOD_MAX) ? PERIOD_MAX : cfg_wdata_i;

  fgts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (need_div),
    .dividend_i (div_dividend),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // finish arithmetic shared by both operations
  assign rem_nz   = |div_rem;
  assign inc      = (op_q == OP_SUBMIT) && rem_nz;
  assign cnt_sum  = SUM_W'(pending_q) + SUM_W'(div_quot) + SUM_W'(inc);
  assign cnt_sat  = (cnt_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
  assign tick_sum = {1'b0, t_q} + SUM_W'(period_q - div_rem);
  assign tick_sat = tick_sum[TIME_W] ? TIME_MAX : tick_sum[TIME_W-1:0];
  assign next_fin = ((op_q == OP_SUBMIT) && !rem_nz) ? t_q : tick_sat;
  assign sched    = t_q - TIME_W'(div_rem);
  assign delay    = (t_q > req_time_q) ? (t_q - req_time_q) : '0;

  assign fin_go  = (state_q == ST_FIN) &&
                   ((op_q == OP_SUBMIT) || !m_valid_q || m_axis_tready);
  assign fin_out = fin_go && (op_q == OP_POLL);

  always_comb begin
    result_d.scheduled_tick = sched;
    result_d.skipped_ticks  = cnt_sat;
    result_d.lateness       = TIME_W'(div_rem);
    result_d.shaping_delay  = delay;
    result_d.output_time    = t_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (need_div) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PERIOD_RESET;
      have_req_q  <= 1'b0;
      req_time_q  <= '0;
      next_tick_q <= '0;
      pending_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q    <= cfg_clamped;
        have_req_q  <= 1'b0;
        req_time_q  <= '0;
        next_tick_q <= '0;
        pending_q   <= '0;
      end else if (s_accept) begin
        if (in_op == OP_SUBMIT) begin
          if (!in_valid) begin
            have_req_q  <= 1'b0;
            req_time_q  <= '0;
            next_tick_q <= '0;
            pending_q   <= '0;
          end else begin
            have_req_q <= 1'b1;
            req_time_q <= in_time;
            if (next_tick_q == '0) begin
              next_tick_q <= in_time;
            end
          end
        end
      end else if (fin_go) begin
        next_tick_q <= next_fin;
        pending_q   <= (op_q == OP_SUBMIT) ? cnt_sat : '0;
      end
      if (fin_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q <= in_op;
      t_q  <= in_time;
    end
    if (fin_out) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = result_q;

  `FGTS_ASSERT(a_div_starts, need_div |=> (state_q == ST_DIV), "divider not started")
  `FGTS_ASSERT(a_poll_clears_pending, fin_out |=> (pending_q == '0),
               "pending skips kept after a result")
  `FGTS_ASSERT(a_grid_monotonic,
               (!$past(cfg_we_i) && !$past(clr_accept)) |-> (next_tick_q >= $past(next_tick_q)),
               "grid moved backward")
  `FGTS_ASSERT(a_late_below_period, fin_out |=> (result_q.lateness < TIME_W'(period_q)),
               "lateness not below period")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fgts_pkg::*;

  localparam longint unsigned TMAX_L = TIME_MAX;
  localparam longint unsigned CMAX_L = COUNT_MAX;
  localparam longint unsigned PR = PERIOD_RESET;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic    op;
    logic    vld;
    tstamp_t ts;
    bit      lit;
    result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  period_t cfg_wdata_i = '0;
  logic s_tvalid = 1'b0;
  logic [TIME_W-1:0] s_tdata = '0;
  logic [USER_IN_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [DATA_OUT_W-1:0] m_axis_tdata;

  int snd_idle = 7;
  int rcv_idle = 80;
  bit rcv_hold = 1'b0;
  int err_cnt = 0;
  int cyc_cnt = 0;

  // grid state as the block should hold it
  longint unsigned pr_period;
  longint unsigned pr_req;
  longint unsigned pr_next;
  longint unsigned pr_pend;
  bit pr_have;

  result_t tick_results_q[$];
  stim_row_t stim_rows[$];

  fixed_grid_tick_scheduler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    if (a > lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic void grid_clear();
    pr_have = 1'b0;
    pr_req = 0;
    pr_next = 0;
    pr_pend = 0;
  endfunction

  function automatic void grid_config(period_t v);
    if (v < PERIOD_MIN) v = PERIOD_MIN;
    if (v > PERIOD_MAX) v = PERIOD_MAX;
    pr_period = 64'(v);
    grid_clear();
  endfunction

  function automatic bit tick_grid_predict(input logic op, input logic vld, input tstamp_t ts,
                                           output result_t res);
    longint unsigned t, p, gap, rem, adv, late, tick;
    t = 64'(ts);
    p = pr_period;
    res = '0;
    if (op == OP_SUBMIT) begin
      if (!vld) begin
        grid_clear();
        return 1'b0;
      end
      pr_have = 1'b1;
      pr_req = t;
      if (pr_next == 0) begin
        pr_next = t;
      end else if (pr_next < t) begin
        gap = t - pr_next;
        rem = gap % p;
        adv = gap / p;
        if (rem != 0) adv++;
        pr_next = (rem == 0) ? t : sat_sum(t, p - rem, TMAX_L);
        pr_pend = sat_sum(pr_pend, adv, CMAX_L);
      end
      return 1'b0;
    end
    if (!pr_have || t == 0 || t < pr_next) return 1'b0;
    late = t - pr_next;
    tick = t - late % p;
    res.scheduled_tick = tstamp_t'(tick);
    res.skipped_ticks  = count_t'(sat_sum(pr_pend, late / p, CMAX_L));
    res.lateness       = tstamp_t'(t - tick);
    res.shaping_delay  = (t > pr_req) ? tstamp_t'(t - pr_req) : '0;
    res.output_time    = ts;
    pr_next = sat_sum(tick, p, TMAX_L);
    pr_pend = 0;
    return 1'b1;
  endfunction

  function automatic void add_row(logic op, logic vld, longint unsigned ts, bit lit = 1'b0,
                                  longint unsigned tick = 0, longint unsigned skip = 0,
                                  longint unsigned late = 0, longint unsigned delay = 0);
    stim_row_t r;
    r.op = op;
    r.vld = vld;
    r.ts = tstamp_t'(ts);
    r.lit = lit;
    r.res.scheduled_tick = tstamp_t'(tick);
    r.res.skipped_ticks  = count_t'(skip);
    r.res.lateness       = tstamp_t'(late);
    r.res.shaping_delay  = tstamp_t'(delay);
    r.res.output_time    = tstamp_t'(ts);
    stim_rows.push_back(r);
  endfunction

  task automatic send_item(input logic op, input logic vld, input tstamp_t ts,
                           input bit lit, input result_t lit_res);
    result_t res;
    bit due;
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ts;
    s_tuser <= {vld, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    due = tick_grid_predict(op, vld, ts, res);
    if (lit) tick_results_q.push_back(lit_res);
    else if (due) tick_results_q.push_back(res);
  endtask

  task automatic drain_results();
    int n;
    n = 0;
    while (tick_results_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (tick_results_q.size() != 0) begin
      $display("tb_top: %0d results never arrived", tick_results_q.size());
      err_cnt += tick_results_q.size();
      tick_results_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin : rx_check
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      got = result_t'(m_axis_tdata);
      if (tick_results_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("tb_top: unexpected transaction tick=%0d skipped=%0d late=%0d",
                   got.scheduled_tick, got.skipped_ticks, got.lateness);
      end else begin
        want = tick_results_q.pop_front();
        if (got.scheduled_tick !== want.scheduled_tick ||
            got.skipped_ticks !== want.skipped_ticks ||
            got.lateness !== want.lateness ||
            got.shaping_delay !== want.shaping_delay ||
            got.output_time !== want.output_time) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("tb_top: mismatch exp tick=%0d skipped=%0d late=%0d delay=%0d now=%0d",
                     want.scheduled_tick, want.skipped_ticks, want.lateness,
                     want.shaping_delay, want.output_time);
            $display("tb_top:          got tick=%0d skipped=%0d late=%0d delay=%0d now=%0d",
                     got.scheduled_tick, got.skipped_ticks, got.lateness,
                     got.shaping_delay, got.output_time);
          end
        end
      end
    end
    m_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    logic op, vld;
    tstamp_t ts;
    period_t cfg_val;
    longint unsigned base, x;
    int unsigned pu;
    int r, k;

    pr_period = 64'(PERIOD_RESET);
    grid_clear();

    // directed sequence at the reset period
    add_row(OP_SUBMIT, 1'b0, TMAX_L);
    add_row(OP_POLL,   1'b1, 1000);
    add_row(OP_SUBMIT, 1'b1, 0);
    add_row(OP_POLL,   1'b0, 0);
    add_row(OP_POLL,   1'b0, 5, 1'b1, 0, 0, 5, 5);
    add_row(OP_POLL,   1'b0, PR - 1);
    add_row(OP_SUBMIT, 1'b1, 10 * PR);
    add_row(OP_POLL,   1'b1, 10 * PR, 1'b1, 10 * PR, 9, 0, 0);
    add_row(OP_POLL,   1'b0, 13 * PR + 7);
    add_row(OP_SUBMIT, 1'b0, 0);
    add_row(OP_SUBMIT, 1'b1, 1000);
    add_row(OP_POLL,   1'b0, 999);
    add_row(OP_SUBMIT, 1'b1, 500);
    add_row(OP_POLL,   1'b0, 1000, 1'b1, 1000, 0, 0, 500);
    add_row(OP_SUBMIT, 1'b1, 1001 + PR);
    add_row(OP_POLL,   1'b0, 1003 + 4 * PR);
    add_row(OP_SUBMIT, 1'b1, TMAX_L);
    add_row(OP_POLL,   1'b1, TMAX_L);
    add_row(OP_POLL,   1'b0, TMAX_L);
    add_row(OP_SUBMIT, 1'b0, TMAX_L);
    add_row(OP_SUBMIT, 1'b1, 1);
    add_row(OP_POLL,   1'b0, 1, 1'b1, 1, 0, 0, 0);
    add_row(OP_POLL,   1'b1, 1);
    add_row(OP_POLL,   1'b0, TMAX_L);
    add_row(OP_SUBMIT, 1'b0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      send_item(stim_rows[i].op, stim_rows[i].vld, stim_rows[i].ts, stim_rows[i].lit,
                stim_rows[i].res);
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: cfg_val = '0;
        1: cfg_val = '1;
        2: cfg_val = PERIOD_MIN;
        3: cfg_val = PERIOD_MAX;
        4: cfg_val = period_t'($urandom_range(PERIOD_MAX, PERIOD_MIN));
        default: cfg_val = period_t'($urandom());
      endcase
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= cfg_val;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      grid_config(cfg_val);

      if (ph < 2) begin
        snd_idle = 7;
        rcv_idle <= 80;
      end else if (ph < 4) begin
        snd_idle = 80;
        rcv_idle <= 7;
      end else begin
        snd_idle = 0;
        rcv_idle <= 0;
      end

      // stall the output long enough for the block to back up its input
      if (ph == 4) begin
        fork
          begin
            rcv_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            rcv_hold <= 1'b0;
          end
        join_none
      end

      repeat (PHASE_ITEMS) begin
        pu = 32'(pr_period);
        r = $urandom_range(99);
        op = OP_SUBMIT;
        vld = 1'b1;
        if (r < 2) begin
          op = 1'($urandom_range(1));
          vld = 1'($urandom_range(1));
          ts = tstamp_t'({$urandom(), $urandom()});
        end else if (r < 5) begin
          vld = 1'b0;
          ts = tstamp_t'({$urandom(), $urandom()});
        end else if (!pr_have) begin
          k = $urandom_range(19);
          if (k == 0) ts = '0;
          else if (k < 3) ts = tstamp_t'(TMAX_L - 64'($urandom_range(3 * pu)));
          else ts = tstamp_t'({$urandom_range(255), $urandom()});
        end else if (r < 20) begin
          x = 64'($urandom_range(7 * pu));
          base = sat_sum(pr_next, x, TMAX_L);
          ts = tstamp_t'((base >= pu) ? base - pu : base);
        end else begin
          op = OP_POLL;
          vld = 1'($urandom_range(1));
          k = $urandom_range(99);
          if (k < 10) begin
            ts = (pr_next > pu) ? tstamp_t'(pr_next - 1 - $urandom_range(pu - 1)) : '0;
          end else begin
            if (k < 75) x = 64'($urandom_range(pu - 1));
            else if (k < 93) x = 64'($urandom_range(5, 1) * pu + $urandom_range(pu - 1));
            else x = {$urandom_range(15), $urandom()};
            ts = tstamp_t'(sat_sum(pr_next, x, TMAX_L));
          end
        end
        send_item(op, vld, ts, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    drain_results();
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fgts_pkg.sv
src/fgts_div.sv
src/fixed_grid_tick_scheduler_unit.sv
verif/tb_top.sv
